// File: sv/pvp_pkg.sv
// ============================================================================
// pvp_pkg: shared types and constants for the perspective vertex projector
// Holds the payload structs, register indexes and sizing constants.
// ============================================================================
package pvp_pkg;

    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned CoordW          = 32;
    localparam int unsigned SumW            = 34;
    localparam int unsigned SizeW           = 13;
    localparam int unsigned CfgIdxW         = 3;
    localparam int unsigned FifoDepth       = 4;

    localparam logic [SizeW-1:0] WidthReset  = 13'd640;
    localparam logic [SizeW-1:0] HeightReset = 13'd480;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_OBJ_X  = 3'd3,
        REG_OBJ_Y  = 3'd4,
        REG_OBJ_Z  = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CoordW-1:0] vert_x;
        logic signed [CoordW-1:0] vert_y;
        logic signed [CoordW-1:0] vert_z;
    } t_vertex;

    typedef struct packed {
        logic signed [CoordW-1:0] screen_x;
        logic signed [CoordW-1:0] screen_y;
        logic signed [CoordW-1:0] view_depth;
        logic                     culled;
        logic                     div_error;
    } t_result;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [SumW-1:0] x;
        logic signed [SumW-1:0] y;
        logic signed [SumW-1:0] z;
        logic                   culled;
        logic                   div_error;
    } t_work;

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return hi[CoordW-1:0];
        end else if (v < lo) begin
            return lo[CoordW-1:0];
        end
        return v[CoordW-1:0];
    endfunction

endpackage

// File: sv/perspective_vertex_project.sv
// ============================================================================
// perspective_vertex_project: vertex projection to screen space
// Offset, cull, perspective divide and viewport map, one vertex per cycle.
// ============================================================================
// A vertex is taken on any cycle with start high; busy stays low, so one
// vertex enters every clock. Each vertex yields one result strobe after
// passing through the offset-add register, the queue, the pipelined
// divider (one bit per stage over 34 + FRAC_BITS stages), the scaling
// registers and the output register. The receiver cannot stall.
module perspective_vertex_project #(
    parameter int unsigned FRAC_BITS = pvp_pkg::FracBitsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pvp_pkg::t_vertex             i_vert,
    output logic                         o_strobe,
    output pvp_pkg::t_result             o_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pvp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [31:0]                  i_cfg_data
);
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [31:0] r_obj_x, r_obj_y, r_obj_z;
    logic [pvp_pkg::SizeW-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x  <= '0;
            r_cam_y  <= '0;
            r_cam_z  <= '0;
            r_obj_x  <= '0;
            r_obj_y  <= '0;
            r_obj_z  <= '0;
            r_width  <= pvp_pkg::WidthReset;
            r_height <= pvp_pkg::HeightReset;
        end else if (i_cfg_valid) begin
            case (pvp_pkg::t_cfg_idx'(i_cfg_idx))
                pvp_pkg::REG_CAM_X:  r_cam_x  <= i_cfg_data;
                pvp_pkg::REG_CAM_Y:  r_cam_y  <= i_cfg_data;
                pvp_pkg::REG_CAM_Z:  r_cam_z  <= i_cfg_data;
                pvp_pkg::REG_OBJ_X:  r_obj_x  <= i_cfg_data;
                pvp_pkg::REG_OBJ_Y:  r_obj_y  <= i_cfg_data;
                pvp_pkg::REG_OBJ_Z:  r_obj_z  <= i_cfg_data;
                pvp_pkg::REG_WIDTH:  r_width  <= i_cfg_data[pvp_pkg::SizeW-1:0];
                pvp_pkg::REG_HEIGHT: r_height <= i_cfg_data[pvp_pkg::SizeW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    logic                   w_fv;
    pvp_pkg::t_work         w_fw;
    pvp_pkg::t_work         w_fw_adj;

    // front adds vertex plus camera; object offset added here to keep exact sum
    pvp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(start & ~busy), .i_vert(i_vert),
        .i_off_x(r_cam_x), .i_off_y(r_cam_y), .i_off_z(r_cam_z),
        .o_valid(w_fv), .o_work(w_fw)
    );

    logic signed [pvp_pkg::SumW-1:0] r_ox, r_oy, r_oz;
    always_ff @(posedge i_clk) begin
        r_ox <= pvp_pkg::SumW'(r_obj_x);
        r_oy <= pvp_pkg::SumW'(r_obj_y);
        r_oz <= pvp_pkg::SumW'(r_obj_z);
    end

    always_comb begin
        w_fw_adj           = w_fw;
        w_fw_adj.x         = w_fw.x + r_ox;
        w_fw_adj.y         = w_fw.y + r_oy;
        w_fw_adj.z         = w_fw.z + r_oz;
        w_fw_adj.culled    = (w_fw_adj.z > 0);
        w_fw_adj.div_error = (w_fw_adj.z == '0);
    end

    logic           w_empty;
    pvp_pkg::t_work w_qd;

    pvp_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(w_fv), .i_data(w_fw_adj),
        .i_pop(~w_empty), .o_empty(w_empty), .o_data(w_qd)
    );

    pvp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(~w_empty), .i_work(w_qd),
        .i_width(r_width), .i_height(r_height),
        .o_valid(o_strobe), .o_res(o_res)
    );
endmodule

// File: sv/pvp_front.sv
// ============================================================================
// pvp_front: offset adder and classifier
// Adds the camera offsets, flags culled and zero-depth vertices.
// ============================================================================
module pvp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pvp_pkg::t_vertex              i_vert,
    input  logic signed [31:0]            i_off_x,
    input  logic signed [31:0]            i_off_y,
    input  logic signed [31:0]            i_off_z,
    output logic                          o_valid,
    output pvp_pkg::t_work                o_work
);
    logic           r_valid;
    pvp_pkg::t_work r_work;
    pvp_pkg::t_work n_work;

    always_comb begin
        n_work.x = pvp_pkg::SumW'(i_vert.vert_x) + pvp_pkg::SumW'(i_off_x);
        n_work.y = pvp_pkg::SumW'(i_vert.vert_y) + pvp_pkg::SumW'(i_off_y);
        n_work.z = pvp_pkg::SumW'(i_vert.vert_z) + pvp_pkg::SumW'(i_off_z);
        n_work.culled    = (n_work.z > 0);
        n_work.div_error = (n_work.z == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
endmodule

// File: sv/pvp_fifo.sv
// ============================================================================
// pvp_fifo: short queue between front and back
// Small register FIFO that decouples classification from projection.
// ============================================================================
module pvp_fifo #(
    parameter int unsigned DEPTH = pvp_pkg::FifoDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pvp_pkg::t_work i_data,
    input  logic           i_pop,
    output logic           o_empty,
    output pvp_pkg::t_work o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pvp_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= inc(r_rd);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
endmodule

// File: sv/pvp_div.sv
// ============================================================================
// pvp_div: pipelined restoring divider
// Unsigned quotient of a NUM_W numerator by a DEN_W divisor, one bit a stage.
// ============================================================================
module pvp_div #(
    parameter int unsigned NUM_W = 50,
    parameter int unsigned DEN_W = 34,
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);
    logic             r_vld [1:NUM_W];
    logic [NUM_W-1:0] r_q   [1:NUM_W];
    logic [DEN_W-1:0] r_rem [1:NUM_W];
    logic [DEN_W-1:0] r_den [1:NUM_W];
    logic [TAG_W-1:0] r_tag [1:NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic             w_vld;
        logic [NUM_W-1:0] w_q;
        logic [DEN_W-1:0] w_rem;
        logic [DEN_W-1:0] w_den;
        logic [TAG_W-1:0] w_tag;
        logic [DEN_W:0]   w_shift;
        logic [DEN_W+1:0] w_diff;

        if (s == 0) begin : g_first
            assign w_vld = i_valid;
            assign w_q   = i_num;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_tag = i_tag;
        end else begin : g_rest
            assign w_vld = r_vld[s];
            assign w_q   = r_q[s];
            assign w_rem = r_rem[s];
            assign w_den = r_den[s];
            assign w_tag = r_tag[s];
        end

        // remainder stays below the divisor, so DEN_W bits hold it
        assign w_shift = {w_rem, w_q[NUM_W-1]};
        assign w_diff  = {1'b0, w_shift} - {2'b0, w_den};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= w_vld;
            end
            r_den[s+1] <= w_den;
            r_tag[s+1] <= w_tag;
            if (!w_diff[DEN_W+1]) begin
                r_rem[s+1] <= w_diff[DEN_W-1:0];
                r_q[s+1]   <= {w_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= w_shift[DEN_W-1:0];
                r_q[s+1]   <= {w_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_q[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

// File: sv/pvp_back.sv
// ============================================================================
// pvp_back: projection and viewport mapping
// Divides x and y by depth, scales by viewport size, saturates results.
// ============================================================================
module pvp_back #(
    parameter int unsigned FRAC_BITS = pvp_pkg::FracBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pvp_pkg::t_work                i_work,
    input  logic [pvp_pkg::SizeW-1:0]     i_width,
    input  logic [pvp_pkg::SizeW-1:0]     i_height,
    output logic                          o_valid,
    output pvp_pkg::t_result              o_res
);
    localparam int unsigned SW   = pvp_pkg::SumW;
    localparam int unsigned NW   = SW + FRAC_BITS;
    localparam int unsigned TAGW = SW + 3;
    localparam int unsigned QW   = 42;
    localparam int unsigned PW   = QW + pvp_pkg::SizeW + 1;

    // tag: z, x sign, culled, div_error; y sign rides with the y divider
    logic [SW-1:0] w_zmag;
    logic [SW-1:0] w_xmag;
    logic [SW-1:0] w_ymag;
    logic [NW-1:0] w_qx;
    logic [NW-1:0] w_qy;
    logic          w_dvld;
    logic          w_dvld_y;
    logic [TAGW-1:0] w_tag_in;
    logic [TAGW-1:0] w_tag;
    logic [0:0]      w_tag_y;
    logic            w_zero;

    assign w_zero = i_work.culled | i_work.div_error;
    assign w_zmag = w_zero ? SW'(1) : SW'(-i_work.z);
    assign w_xmag = i_work.x[SW-1] ? SW'(-i_work.x) : i_work.x;
    assign w_ymag = i_work.y[SW-1] ? SW'(-i_work.y) : i_work.y;
    assign w_tag_in = {i_work.z, i_work.x[SW-1], i_work.culled, i_work.div_error};

    pvp_div #(.NUM_W(NW), .DEN_W(SW), .TAG_W(TAGW)) u_div_x (
        .i_clk, .i_rst_n, .i_valid(i_valid),
        .i_num({w_xmag, FRAC_BITS'(0)}), .i_den(w_zmag), .i_tag(w_tag_in),
        .o_valid(w_dvld), .o_quo(w_qx), .o_tag(w_tag)
    );

    pvp_div #(.NUM_W(NW), .DEN_W(SW), .TAG_W(1)) u_div_y (
        .i_clk, .i_rst_n, .i_valid(i_valid),
        .i_num({w_ymag, FRAC_BITS'(0)}), .i_den(w_zmag), .i_tag(i_work.y[SW-1]),
        .o_valid(w_dvld_y), .o_quo(w_qy), .o_tag(w_tag_y)
    );

    // z negative: sign of x/z is inverse of sign of x
    logic signed [QW-1:0] w_sqx;
    logic signed [QW-1:0] w_sqy;
    logic [QW-2:0]        w_cap;
    logic [QW-2:0]        w_mx;
    logic [QW-2:0]        w_my;
    assign w_cap = (QW-1)'(1) << 40;
    assign w_mx  = (w_qx > NW'(w_cap)) ? w_cap : (QW-1)'(w_qx);
    assign w_my  = (w_qy > NW'(w_cap)) ? w_cap : (QW-1)'(w_qy);
    assign w_sqx = w_tag[2] ? QW'(w_mx) : -QW'(w_mx);
    assign w_sqy = w_tag_y[0] ? QW'(w_my) : -QW'(w_my);

    logic                 r_s1_vld;
    logic signed [QW-1:0] r_ax;
    logic signed [QW-1:0] r_ay;
    logic [TAGW-1:0]      r_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_dvld & w_dvld_y;
        end
        r_ax     <= w_sqx + (QW'(1) <<< FRAC_BITS);
        r_ay     <= (QW'(1) <<< FRAC_BITS) - w_sqy;
        r_s1_tag <= w_tag;
    end

    // product is 42x14 signed: split into two 21-bit halves, summed below
    logic                 r_s2_vld;
    logic signed [PW-1:0] r_plx;
    logic signed [PW-1:0] r_ply;
    logic signed [PW-1:0] r_phx;
    logic signed [PW-1:0] r_phy;
    logic [TAGW-1:0]      r_s2_tag;
    logic signed [pvp_pkg::SizeW:0] w_w;
    logic signed [pvp_pkg::SizeW:0] w_h;
    assign w_w = {1'b0, i_width};
    assign w_h = {1'b0, i_height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_plx <= PW'($signed({1'b0, r_ax[20:0]})) * PW'(w_w);
        r_ply <= PW'($signed({1'b0, r_ay[20:0]})) * PW'(w_h);
        r_phx <= PW'($signed(r_ax[QW-1:21])) * PW'(w_w);
        r_phy <= PW'($signed(r_ay[QW-1:21])) * PW'(w_h);
        r_s2_tag <= r_s1_tag;
    end

    logic signed [PW-1:0] w_px;
    logic signed [PW-1:0] w_py;
    logic signed [PW-1:0] w_hx;
    logic signed [PW-1:0] w_hy;
    assign w_px = (r_phx <<< 21) + r_plx;
    assign w_py = (r_phy <<< 21) + r_ply;
    // divide by 2 toward zero
    assign w_hx = (w_px + $signed(PW'(w_px[PW-1]))) >>> 1;
    assign w_hy = (w_py + $signed(PW'(w_py[PW-1]))) >>> 1;

    logic signed [SW-1:0] w_z;
    logic                 w_cul;
    logic                 w_der;
    assign w_z   = r_s2_tag[TAGW-1 -: SW];
    assign w_cul = r_s2_tag[1];
    assign w_der = r_s2_tag[0];

    logic             r_vld;
    pvp_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_s2_vld;
        end
        r_res.culled     <= w_cul;
        r_res.div_error  <= w_der;
        r_res.view_depth <= pvp_pkg::sat32(64'(w_z));
        if (w_cul || w_der) begin
            r_res.screen_x <= '0;
            r_res.screen_y <= '0;
        end else begin
            r_res.screen_x <= pvp_pkg::sat32(64'(w_hx));
            r_res.screen_y <= pvp_pkg::sat32(64'(w_hy));
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;
endmodule

// File: sv/pvp_checker.sv
// ============================================================================
// pvp_checker: port-level checks for the vertex projector
// Watches the result flags, the screen and depth fields they govern, and busy.
// ============================================================================
module pvp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             o_strobe,
    input pvp_pkg::t_result o_res
);
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_res.culled && o_res.div_error))
        else $error("culled and div_error both set");

    a_cull_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.culled) |-> (o_res.screen_x == '0 && o_res.screen_y == '0))
        else $error("culled vertex with nonzero screen fields");

    a_derr_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.div_error) |-> (o_res.view_depth == '0))
        else $error("div_error with nonzero depth");

    a_cull_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.culled) |-> (o_res.view_depth > 0))
        else $error("culled vertex with nonpositive depth");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");
endmodule

bind perspective_vertex_project pvp_checker u_pvp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_strobe(o_strobe), .o_res(o_res)
);

// File: verif/perspective_vertex_project_test.sv
`timescale 1ns / 1ps
// ============================================================================
// perspective_vertex_project_test: self-checking bench for the projector
// Drives vertices through offset, cull, divide and viewport mapping under
// several register settings; every result strobe is checked per field
// against a typed-in answer or an in-bench projection model.
// ============================================================================
module perspective_vertex_project_test;

    localparam int Frac      = 16;
    localparam int Latency   = Frac + 40;
    localparam longint Limit = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    pvp_pkg::t_vertex i_vert = '0;
    logic        o_strobe;
    pvp_pkg::t_result o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [pvp_pkg::CfgIdxW-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    perspective_vertex_project dut (
        .i_clk, .i_rst_n, .start, .busy, .i_vert, .o_strobe, .o_res,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_idx, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the register file
    logic signed [31:0] cam_x, cam_y, cam_z, obj_x, obj_y, obj_z;
    logic [12:0]        view_w, view_h;

    pvp_pkg::t_result pending_results[$];
    int      errors = 0;
    int      results_seen = 0;
    int      culled_seen = 0;
    int      zdiv_seen = 0;
    longint  cycles = 0;
    int      send_gap_pct = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] fixed_ratio(input logic signed [63:0] num,
                                                       input logic signed [63:0] den);
        logic signed [63:0] q;
        q = (num <<< Frac) / den;
        if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
        if (q < -(64'sd1 <<< 40)) q = -(64'sd1 <<< 40);
        return q;
    endfunction

    function automatic pvp_pkg::t_result project(input pvp_pkg::t_vertex v);
        pvp_pkg::t_result r;
        logic signed [63:0] x, y, z, qx, qy, one;
        one = 64'sd1 <<< Frac;
        x = 64'(v.vert_x) + 64'(cam_x) + 64'(obj_x);
        y = 64'(v.vert_y) + 64'(cam_y) + 64'(obj_y);
        z = 64'(v.vert_z) + 64'(cam_z) + 64'(obj_z);
        r = '0;
        r.view_depth = clamp32(z);
        if (z > 0) begin
            r.culled = 1'b1;
        end else if (z == 0) begin
            r.div_error = 1'b1;
        end else begin
            qx = fixed_ratio(x, z);
            qy = fixed_ratio(y, z);
            r.screen_x = clamp32(((qx + one) * $signed({51'd0, view_w})) / 2);
            r.screen_y = clamp32(((one - qy) * $signed({51'd0, view_h})) / 2);
        end
        return r;
    endfunction

    task automatic write_reg(input pvp_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pvp_pkg::REG_CAM_X:  cam_x = data;
            pvp_pkg::REG_CAM_Y:  cam_y = data;
            pvp_pkg::REG_CAM_Z:  cam_z = data;
            pvp_pkg::REG_OBJ_X:  obj_x = data;
            pvp_pkg::REG_OBJ_Y:  obj_y = data;
            pvp_pkg::REG_OBJ_Z:  obj_z = data;
            pvp_pkg::REG_WIDTH:  view_w = data[12:0];
            pvp_pkg::REG_HEIGHT: view_h = data[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] cx, cy, cz, ox, oy, oz,
                                 input logic [31:0] w, h);
        write_reg(pvp_pkg::REG_CAM_X, cx);
        write_reg(pvp_pkg::REG_CAM_Y, cy);
        write_reg(pvp_pkg::REG_CAM_Z, cz);
        write_reg(pvp_pkg::REG_OBJ_X, ox);
        write_reg(pvp_pkg::REG_OBJ_Y, oy);
        write_reg(pvp_pkg::REG_OBJ_Z, oz);
        write_reg(pvp_pkg::REG_WIDTH, w);
        write_reg(pvp_pkg::REG_HEIGHT, h);
    endtask

    // transfer one vertex; optionally with a known answer typed in
    task automatic send_vertex(input pvp_pkg::t_vertex v, input bit fixed_answer,
                               input pvp_pkg::t_result answer);
        while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_vert <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(fixed_answer ? answer : project(v));
        @(negedge i_clk);
    endtask

    // drop start at once: the last vertex has already been taken
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (Latency + 4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000 | $urandom_range(3, 0);
            1: return 32'h7FFF_FFFF - $urandom_range(3, 0);
            2: return $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic pvp_pkg::t_vertex rand_vertex();
        pvp_pkg::t_vertex v;
        v.vert_x = rand_coord();
        v.vert_y = rand_coord();
        // mostly in front of the camera, some at zero depth or behind it
        case ($urandom_range(9, 0))
            0:       v.vert_z = -(cam_z + obj_z);
            1:       v.vert_z = $urandom_range(32'h0010_0000, 1);
            2:       v.vert_z = rand_coord();
            default: v.vert_z = -$signed({1'b0, 31'($urandom_range(32'h0100_0000, 1))});
        endcase
        return v;
    endfunction

    // check each strobe against the oldest expectation
    always @(posedge i_clk) begin
        pvp_pkg::t_result exp_r;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result strobe");
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    results_seen++;
                    if (exp_r.culled) culled_seen++;
                    if (exp_r.div_error) zdiv_seen++;
                    if (o_res.screen_x !== exp_r.screen_x) begin
                        $error("screen_x exp %0d got %0d", exp_r.screen_x, o_res.screen_x);
                        errors++;
                    end
                    if (o_res.screen_y !== exp_r.screen_y) begin
                        $error("screen_y exp %0d got %0d", exp_r.screen_y, o_res.screen_y);
                        errors++;
                    end
                    if (o_res.view_depth !== exp_r.view_depth) begin
                        $error("view_depth exp %0d got %0d", exp_r.view_depth,
                               o_res.view_depth);
                        errors++;
                    end
                    if (o_res.culled !== exp_r.culled) begin
                        $error("culled exp %0b got %0b", exp_r.culled, o_res.culled);
                        errors++;
                    end
                    if (o_res.div_error !== exp_r.div_error) begin
                        $error("div_error exp %0b got %0b", exp_r.div_error,
                               o_res.div_error);
                        errors++;
                    end
                end
            end
            if (cycles > Limit) begin
                $display("perspective_vertex_project: mismatch");
                $finish;
            end
        end
    end

    typedef struct {
        pvp_pkg::t_vertex v;
        bit               fixed_answer;
        pvp_pkg::t_result answer;
    } t_stim_row;

    initial begin
        t_stim_row rows[$];
        pvp_pkg::t_result r;
        int        phase;
        cam_x = 0; cam_y = 0; cam_z = 0; obj_x = 0; obj_y = 0; obj_z = 0;
        view_w = 13'd640; view_h = 13'd480;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows at reset settings
        r = '0; r.div_error = 1'b1;
        rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, r});
        r = '0; r.culled = 1'b1; r.view_depth = 32'sh7FFF_FFFF;
        rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b1, r});
        r = '0; r.culled = 1'b1; r.view_depth = 32'sd1;
        rows.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1}, 1'b1, r});
        // on-axis vertex lands in the viewport center
        r = '0; r.screen_x = 32'sd320 <<< 16; r.screen_y = 32'sd240 <<< 16;
        r.view_depth = -32'sd65536;
        rows.push_back('{'{32'sd0, 32'sd0, -32'sd65536}, 1'b1, r});
        rows.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1}, 1'b0, r});
        rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0, r});
        rows.push_back('{'{32'sd65536, -32'sd65536, -32'sd65536}, 1'b0, r});
        rows.push_back('{'{-32'sd32768, 32'sd98304, -32'sd131072}, 1'b0, r});
        rows.push_back('{'{32'hFFFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555}, 1'b0, r});
        foreach (rows[i]) send_vertex(rows[i].v, rows[i].fixed_answer, rows[i].answer);
        drain();

        // unknown register indexes do not exist at this width; sizes at extremes
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                 32'd1, 32'd4096);
                1: load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'd4096, 32'd1);
                2: load_settings(32'hFFFF_0000, 32'h0001_8000, 32'hFFFE_0000,
                                 32'h0000_4000, 32'hFFFF_C000, 32'd0,
                                 32'd8191, 32'd0);
                3: load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                 32'd0, 32'hFFFF_FFFF);
                default: load_settings($urandom(), $urandom(),
                                       -$urandom_range(32'h0040_0000, 0),
                                       $urandom(), $urandom(),
                                       -$urandom_range(32'h0040_0000, 0),
                                       $urandom_range(4096, 1), $urandom_range(4096, 1));
            endcase
            send_gap_pct = (phase < 2) ? 6 : (phase < 4) ? 88 : 0;
            for (int i = 0; i < 160; i++) send_vertex(rand_vertex(), 1'b0, r);
            drain();
        end

        $display("covered %0d results: %0d culled, %0d zero depth, 7 register settings",
                 results_seen, culled_seen, zdiv_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("perspective_vertex_project: match");
        end else begin
            $display("perspective_vertex_project: mismatch");
        end
        $finish;
    end
endmodule
